FILE: rtl/line_normal_form_signed_distance_defines.svh
// Assertion macros used by the top level RTL of the line distance block.
`ifndef LINE_NORMAL_FORM_SIGNED_DISTANCE_DEFINES_SVH
`define LINE_NORMAL_FORM_SIGNED_DISTANCE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define LNSD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("lnsd check failed");
`define LNSD_ASSERT_RST(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("lnsd reset check failed");
`else
`define LNSD_ASSERT(lbl, clk, rst, prop)
`define LNSD_ASSERT_RST(lbl, clk, prop)
`endif
`endif

FILE: rtl/lnsd_pkg.sv
// Types and fixed widths of the line distance block.
package lnsd_pkg;
   localparam int IN_W   = 16;
   localparam int MAG_W  = 17;
   localparam int SQ_W   = 33;
   localparam int COEF_W = 16;
   localparam int C_W    = 31;
   localparam int D_W    = 32;

   typedef struct packed {
      logic                   deg;
      logic                   neg_a;
      logic                   neg_b;
      logic signed [IN_W-1:0] x1;
      logic signed [IN_W-1:0] y1;
      logic signed [IN_W-1:0] qx;
      logic signed [IN_W-1:0] qy;
   } side_type;
endpackage

FILE: rtl/lnsd_lane.sv
// Pipelined digit-by-digit search for round(mag * 2^F / sqrt(len2)).
module lnsd_lane #(
   parameter int FRAC_BITS = 14
) (
   input  logic                        clock,
   input  logic                        advance,
   input  logic [lnsd_pkg::SQ_W-1:0]   sq,
   input  logic [lnsd_pkg::SQ_W-1:0]   len2,
   output logic [FRAC_BITS:0]          n_out
);
   import lnsd_pkg::*;

   localparam int STG = FRAC_BITS + 1;
   localparam int PW  = 2 * FRAC_BITS + SQ_W + 6;

   // p: (2n-1)^2*len2, q: (2n-1)*len2, r: 4*mag^2*2^(2F)
   logic signed [PW-1:0]  p_ff [1:STG];
   logic signed [PW-1:0]  q_ff [1:STG];
   logic signed [PW-1:0]  r_ff [1:STG];
   logic signed [PW-1:0]  l_ff [1:STG];
   logic [FRAC_BITS:0]    n_ff [1:STG];

   for (genvar k = 0; k < STG; k++) begin : g_stage
      localparam int BI = FRAC_BITS - k;
      localparam int PK = (k == 0) ? 1 : k;
      logic signed [PW-1:0] p_cur, q_cur, r_cur, l_cur;
      logic [FRAC_BITS:0]   n_cur;
      logic signed [PW-1:0] trial_in;
      logic                 ok_in;
      always_comb begin
         if (k == 0) begin
            p_cur = PW'(len2);
            q_cur = -$signed(PW'(len2));
            r_cur = $signed(PW'(sq)) <<< (2 * FRAC_BITS + 2);
            l_cur = PW'(len2);
            n_cur = '0;
         end else begin
            p_cur = p_ff[PK];
            q_cur = q_ff[PK];
            r_cur = r_ff[PK];
            l_cur = l_ff[PK];
            n_cur = n_ff[PK];
         end
         trial_in = p_cur + (q_cur <<< (BI + 2)) + (l_cur <<< (2 * BI + 2));
         ok_in    = trial_in <= r_cur;
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            p_ff[k+1] <= ok_in ? trial_in : p_cur;
            q_ff[k+1] <= ok_in ? q_cur + (l_cur <<< (BI + 1)) : q_cur;
            r_ff[k+1] <= r_cur;
            l_ff[k+1] <= l_cur;
            n_ff[k+1] <= n_cur | ((FRAC_BITS+1)'(ok_in) << BI);
         end
      end
   end

   assign n_out = n_ff[STG];
endmodule

FILE: rtl/line_normal_form_signed_distance.sv
// Top level: point to line signed distance in normal form, fully pipelined.
// Usage:
//   req_ channel carries one beat per query: two line points and the query
//   point, six signed 16-bit coordinates packed in req_tdata.
//   rsp_ channel returns one beat per query: A, B (Q1.F), C and the signed
//   distance (F fraction bits) in rsp_tdata, and the degenerate flag in
//   rsp_tuser, set when both line points coincide (all fields then zero).
//   From request beat to response beat the beat passes three front stages
//   that form the differences, squares and squared length, FRAC_BITS + 1
//   stages that each settle one bit of A and B, and three back stages that
//   form the products, the sums, and the distance with saturation into the
//   output register that holds the beat.
//   Throughput is one beat per cycle; the bit-settling pipeline of the two
//   lanes sets the depth, not the rate.
//   When rsp_tready is low with a beat held, the whole pipeline freezes and
//   req_tready drops in the same cycle; nothing is lost or repeated.
//   Reset clears every valid bit; payload registers hold stale data.
module line_normal_form_signed_distance #(
   parameter int FRAC_BITS = 14
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,  // line_x1, line_y1, line_x2, line_y2, query_x, query_y
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,  // coef_a, coef_b, coef_c, distance, zero pad
   output logic        rsp_tuser   // degenerate
);
   import lnsd_pkg::*;
   `include "line_normal_form_signed_distance_defines.svh"

   localparam int NW   = FRAC_BITS + 1;
   localparam int AW   = FRAC_BITS + 2;
   localparam int PRW  = AW + IN_W;
   localparam int CW   = (AW + 18 > 34) ? AW + 18 : 34;
   localparam int LLAT = FRAC_BITS + 1;

   logic advance;
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   // front stage 1: differences and magnitudes
   logic signed [IN_W-1:0] x1_in, y1_in, x2_in, y2_in;
   logic signed [MAG_W-1:0] dy_in, nx_in;
   logic          s1_v_ff;
   side_type      s1_side_ff;
   logic [MAG_W-1:0] s1_mdy_ff, s1_mnx_ff;

   always_comb begin
      x1_in = req_tdata[15:0];
      y1_in = req_tdata[31:16];
      x2_in = req_tdata[47:32];
      y2_in = req_tdata[63:48];
      dy_in = MAG_W'(y2_in) - MAG_W'(y1_in);
      nx_in = MAG_W'(x1_in) - MAG_W'(x2_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (advance) begin
         s1_v_ff <= req_tvalid;
      end
      if (advance) begin
         s1_side_ff.deg   <= (dy_in == '0) && (nx_in == '0);
         s1_side_ff.neg_a <= dy_in[MAG_W-1];
         s1_side_ff.neg_b <= nx_in[MAG_W-1];
         s1_side_ff.x1    <= x1_in;
         s1_side_ff.y1    <= y1_in;
         s1_side_ff.qx    <= req_tdata[79:64];
         s1_side_ff.qy    <= req_tdata[95:80];
         s1_mdy_ff <= dy_in[MAG_W-1] ? MAG_W'(-dy_in) : dy_in;
         s1_mnx_ff <= nx_in[MAG_W-1] ? MAG_W'(-nx_in) : nx_in;
      end
   end

   // front stage 2: squares
   logic          s2_v_ff;
   side_type      s2_side_ff;
   logic [SQ_W-1:0] s2_sqa_ff, s2_sqb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (advance) begin
         s2_v_ff <= s1_v_ff;
      end
      if (advance) begin
         s2_side_ff <= s1_side_ff;
         s2_sqa_ff  <= SQ_W'(s1_mdy_ff) * SQ_W'(s1_mdy_ff);
         s2_sqb_ff  <= SQ_W'(s1_mnx_ff) * SQ_W'(s1_mnx_ff);
      end
   end

   // front stage 3: squared length
   logic          s3_v_ff;
   side_type      s3_side_ff;
   logic [SQ_W-1:0] s3_sqa_ff, s3_sqb_ff, s3_len2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (advance) begin
         s3_v_ff <= s2_v_ff;
      end
      if (advance) begin
         s3_side_ff <= s2_side_ff;
         s3_sqa_ff  <= s2_sqa_ff;
         s3_sqb_ff  <= s2_sqb_ff;
         s3_len2_ff <= s2_sqa_ff + s2_sqb_ff;
      end
   end

   // two lanes settle |A| and |B| one bit per stage
   logic [NW-1:0] na, nb;

   lnsd_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_a (
      .clock(clock), .advance(advance),
      .sq(s3_sqa_ff), .len2(s3_len2_ff), .n_out(na)
   );
   lnsd_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_b (
      .clock(clock), .advance(advance),
      .sq(s3_sqb_ff), .len2(s3_len2_ff), .n_out(nb)
   );

   // carry valid and side data alongside the lanes
   logic     lv_ff   [0:LLAT-1];
   side_type lside_ff [0:LLAT-1];

   for (genvar k = 0; k < LLAT; k++) begin : g_side
      always_ff @(posedge clock) begin
         if (reset) begin
            lv_ff[k] <= 1'b0;
         end else if (advance) begin
            lv_ff[k] <= (k == 0) ? s3_v_ff : lv_ff[(k == 0) ? 0 : k-1];
         end
         if (advance) begin
            lside_ff[k] <= (k == 0) ? s3_side_ff : lside_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   // back stage 1: apply signs, form the four products
   logic signed [AW-1:0] a_in, b_in;
   logic          t1_v_ff, t1_deg_ff;
   logic signed [AW-1:0]  t1_a_ff, t1_b_ff;
   logic signed [PRW-1:0] t1_ax_ff, t1_by_ff, t1_aq_ff, t1_bq_ff;

   always_comb begin
      a_in = lside_ff[LLAT-1].neg_a ? -$signed(AW'(na)) : $signed(AW'(na));
      b_in = lside_ff[LLAT-1].neg_b ? -$signed(AW'(nb)) : $signed(AW'(nb));
      if (lside_ff[LLAT-1].deg) begin
         a_in = '0;
         b_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_v_ff <= 1'b0;
      end else if (advance) begin
         t1_v_ff <= lv_ff[LLAT-1];
      end
      if (advance) begin
         t1_deg_ff <= lside_ff[LLAT-1].deg;
         t1_a_ff   <= a_in;
         t1_b_ff   <= b_in;
         t1_ax_ff  <= PRW'(a_in) * PRW'(lside_ff[LLAT-1].x1);
         t1_by_ff  <= PRW'(b_in) * PRW'(lside_ff[LLAT-1].y1);
         t1_aq_ff  <= PRW'(a_in) * PRW'(lside_ff[LLAT-1].qx);
         t1_bq_ff  <= PRW'(b_in) * PRW'(lside_ff[LLAT-1].qy);
      end
   end

   // back stage 2: C and the query dot product
   logic          t2_v_ff, t2_deg_ff;
   logic signed [AW-1:0] t2_a_ff, t2_b_ff;
   logic signed [CW-1:0] t2_c_ff, t2_s_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t2_v_ff <= 1'b0;
      end else if (advance) begin
         t2_v_ff <= t1_v_ff;
      end
      if (advance) begin
         t2_deg_ff <= t1_deg_ff;
         t2_a_ff   <= t1_a_ff;
         t2_b_ff   <= t1_b_ff;
         t2_c_ff   <= -(CW'(t1_ax_ff) + CW'(t1_by_ff));
         t2_s_ff   <= CW'(t1_aq_ff) + CW'(t1_bq_ff);
      end
   end

   // back stage 3: distance and saturation into the output register
   localparam logic signed [CW-1:0] A_HI = $signed(CW'(32767));
   localparam logic signed [CW-1:0] A_LO = $signed(CW'(-32768));
   localparam logic signed [CW-1:0] C_HI = $signed(CW'(1073741823));
   localparam logic signed [CW-1:0] C_LO = $signed(CW'(-1073741824));
   localparam logic signed [CW-1:0] D_HI = $signed(CW'(2147483647));
   localparam logic signed [CW-1:0] D_LO = $signed(CW'(-64'sd2147483648));

   logic signed [CW-1:0] d_in, a_w, b_w;
   logic signed [COEF_W-1:0] a_sat_in, b_sat_in;
   logic signed [C_W-1:0] c_sat_in;
   logic signed [D_W-1:0] d_sat_in;

   always_comb begin
      d_in = t2_s_ff + t2_c_ff;
      a_w  = CW'(t2_a_ff);
      b_w  = CW'(t2_b_ff);
      a_sat_in = (a_w > A_HI) ? COEF_W'(A_HI) : (a_w < A_LO) ? COEF_W'(A_LO) : COEF_W'(a_w);
      b_sat_in = (b_w > A_HI) ? COEF_W'(A_HI) : (b_w < A_LO) ? COEF_W'(A_LO) : COEF_W'(b_w);
      c_sat_in = (t2_c_ff > C_HI) ? C_W'(C_HI) :
                 (t2_c_ff < C_LO) ? C_W'(C_LO) : C_W'(t2_c_ff);
      d_sat_in = (d_in > D_HI) ? D_W'(D_HI) : (d_in < D_LO) ? D_W'(D_LO) : D_W'(d_in);
   end

   logic          rsp_v_ff, rsp_deg_ff;
   logic [95:0]   rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (advance) begin
         rsp_v_ff <= t2_v_ff;
      end
      if (advance) begin
         rsp_deg_ff  <= t2_deg_ff;
         rsp_data_ff <= {1'b0, d_sat_in, c_sat_in, b_sat_in, a_sat_in};
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_deg_ff;

   `LNSD_ASSERT_RST(a_reset_empty, clock, $past(reset) |-> !rsp_tvalid)
   `LNSD_ASSERT(a_deg_zero, clock, reset, rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
   `LNSD_ASSERT(a_unit_nonzero, clock, reset, rsp_tvalid && !rsp_tuser |-> rsp_tdata[31:0] != '0)
   `LNSD_ASSERT(a_stall_hold, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
endmodule

FILE: tb/sv/line_normal_form_signed_distance_checker.sv
// Beat monitor, predictor and scoreboard for the line distance block.
`timescale 1ns / 100ps

module line_normal_form_signed_distance_checker #(
   parameter int FRAC_BITS = 14
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [95:0] req_tdata,  // line_x1, line_y1, line_x2, line_y2, query_x, query_y
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [95:0] rsp_tdata,  // coef_a, coef_b, coef_c, distance, zero pad
   input  logic        rsp_tuser,  // degenerate
   output int          fail_count,
   output int          pending
);
   import lnsd_pkg::*;

   typedef struct packed {
      logic signed [COEF_W-1:0] coef_a;
      logic signed [COEF_W-1:0] coef_b;
      logic signed [C_W-1:0]    coef_c;
      logic signed [D_W-1:0]    distance;
      logic                     degenerate;
   } line_result_t;

   line_result_t awaited_lines[$];
   int           rsp_index;

   // largest n with (2n-1)^2 * len2 <= 4 * mag^2 * 2^(2F): round to nearest, ties away
   function automatic longint unit_part(longint unsigned mag, longint unsigned len2);
      longint unsigned lo, hi, mid, t;
      bit [127:0]      lhs, rhs;
      lo = 0;
      hi = 64'd1 << FRAC_BITS;
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         t   = 2 * mid - 1;
         lhs = 128'(t) * 128'(t) * 128'(len2);
         rhs = (128'(mag) * 128'(mag)) << (2 * FRAC_BITS + 2);
         if (lhs <= rhs) lo = mid;
         else hi = mid - 1;
      end
      return longint'(lo);
   endfunction

   function automatic longint clamp_to(longint v, int w);
      longint top;
      top = (longint'(1) <<< (w - 1)) - 1;
      if (v > top) return top;
      if (v < -top - 1) return -top - 1;
      return v;
   endfunction

   function automatic line_result_t normal_form_of(logic [95:0] beat);
      line_result_t    r;
      longint          x1, y1, x2, y2, qx, qy, dy, nx, a, b, c, d;
      longint unsigned mdy, mnx, len2;
      x1 = longint'($signed(beat[15:0]));
      y1 = longint'($signed(beat[31:16]));
      x2 = longint'($signed(beat[47:32]));
      y2 = longint'($signed(beat[63:48]));
      qx = longint'($signed(beat[79:64]));
      qy = longint'($signed(beat[95:80]));
      dy = y2 - y1;
      nx = x1 - x2;
      mdy = (dy < 0) ? -dy : dy;
      mnx = (nx < 0) ? -nx : nx;
      len2 = mdy * mdy + mnx * mnx;
      r = '0;
      if (len2 == 0) begin
         r.degenerate = 1'b1;
         return r;
      end
      a = unit_part(mdy, len2);
      if (dy < 0) a = -a;
      b = unit_part(mnx, len2);
      if (nx < 0) b = -b;
      c = -(a * x1 + b * y1);
      d = a * qx + b * qy + c;
      r.coef_a   = clamp_to(a, COEF_W);
      r.coef_b   = clamp_to(b, COEF_W);
      r.coef_c   = clamp_to(c, C_W);
      r.distance = clamp_to(d, D_W);
      return r;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch beat %0d %s: got %0d want %0d", rsp_index, field, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending    = 0;
      rsp_index  = 0;
   end

   always @(posedge clock) begin
      line_result_t want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_lines.size() == 0) begin
               $display("unexpected response beat %0d", rsp_index);
               fail_count++;
            end else begin
               want = awaited_lines.pop_front();
               if ($signed(rsp_tdata[15:0]) != want.coef_a)
                  report_mismatch("coef_a", $signed(rsp_tdata[15:0]), want.coef_a);
               if ($signed(rsp_tdata[31:16]) != want.coef_b)
                  report_mismatch("coef_b", $signed(rsp_tdata[31:16]), want.coef_b);
               if ($signed(rsp_tdata[62:32]) != want.coef_c)
                  report_mismatch("coef_c", $signed(rsp_tdata[62:32]), want.coef_c);
               if ($signed(rsp_tdata[94:63]) != want.distance)
                  report_mismatch("distance", $signed(rsp_tdata[94:63]), want.distance);
               if (rsp_tdata[95] !== 1'b0)
                  report_mismatch("pad", rsp_tdata[95], 0);
               if (rsp_tuser !== want.degenerate)
                  report_mismatch("degenerate", rsp_tuser, want.degenerate);
            end
            rsp_index++;
         end
         if (req_tvalid && req_tready) awaited_lines.push_back(normal_form_of(req_tdata));
      end
      pending <= awaited_lines.size();
   end
endmodule

FILE: tb/sv/line_normal_form_signed_distance_tb.sv
// Stimulus, handshake pacing and verdict for the line distance block.
`timescale 1ns / 100ps

module line_normal_form_signed_distance_tb;
   localparam int FRAC_BITS    = 14;
   localparam int LATENCY      = FRAC_BITS + 7;
   localparam int RANDOM_BEATS = 2000;
   localparam int CYCLE_LIMIT  = 600000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [95:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [95:0] rsp_tdata;
   logic        rsp_tuser;
   int          fail_count;
   int          pending;
   int          cycles;
   logic        hold_off;   // raised by the sender, cleared by the receiver

   line_normal_form_signed_distance #(.FRAC_BITS(FRAC_BITS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   line_normal_form_signed_distance_checker #(.FRAC_BITS(FRAC_BITS)) scoreboard (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Guard against a hung handshake.
   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL line_normal_form_signed_distance");
         $finish;
      end
   end

   // Gap length: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(15, 60);
   endfunction

   // Receiver: random stalls, calm stretches, and one long hold-off on request.
   initial begin
      int stall;
      int calm;
      rsp_tready = 1'b0;
      hold_off   = 1'b0;
      stall      = 0;
      calm       = 0;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_tready = 1'b0;
            repeat (300) @(negedge clock);
            hold_off = 1'b0;
         end
         if (calm > 0) begin
            calm--;
            rsp_tready = 1'b1;
         end else if (stall > 0) begin
            stall--;
            rsp_tready = 1'b0;
         end else if ($urandom_range(0, 199) == 0) begin
            calm = $urandom_range(50, 150);
            rsp_tready = 1'b1;
         end else begin
            stall = pick_gap();
            rsp_tready = (stall == 0);
         end
      end
   end

   // Offer one beat after an optional gap; return at the falling edge after acceptance.
   task automatic offer_line(input logic signed [15:0] x1, y1, x2, y2, qx, qy,
                             input int gap);
      req_tvalid = 1'b0;
      repeat (gap) @(negedge clock);
      req_tdata  = {qy, qx, y2, x2, y1, x1};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   function automatic logic signed [15:0] any_coord();
      return 16'($urandom());
   endfunction

   initial begin
      logic signed [15:0] x1, y1, x2, y2, qx, qy;
      int                 kind;
      int                 gap;
      int                 calm;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: extreme spans, axis lines, ties, coincident points, query on the line.
      offer_line(-32768, -32768, 32767, 32767, 32767, -32768, 0);
      offer_line(32767, 32767, -32768, -32768, -32768, 32767, 0);
      offer_line(-32768, 0, 32767, 0, 0, 32767, 0);
      offer_line(0, -32768, 0, 32767, -32768, 0, 0);
      offer_line(32767, -32768, -32768, 32767, 32767, 32767, 0);
      offer_line(5, 5, 5, 5, 100, -100, 0);
      offer_line(-32768, -32768, -32768, -32768, 32767, 32767, 0);
      offer_line(32767, 32767, 32767, 32767, -32768, -32768, 0);
      offer_line(0, 0, 1, 0, 0, 1, 0);
      offer_line(0, 0, 0, 1, 1, 0, 0);
      offer_line(0, 0, -1, 0, 0, -1, 0);
      offer_line(0, 0, 0, -1, -1, 0, 0);
      offer_line(0, 0, 1, 1, 3, -3, 0);
      offer_line(0, 0, 3, 4, 3, 4, 0);
      offer_line(-7, 2, 5, -3, 0, 0, 0);
      offer_line(0, 0, 1, 2, -32768, 32767, 0);
      offer_line(1, 1, 2, 3, 32767, -32768, 0);
      offer_line(-32768, 32767, 32767, -32768, 0, 0, 0);
      offer_line(100, 200, 100, 201, 101, 200, 0);
      offer_line(-1, -1, 0, 0, -1, 0, 0);
      wait (pending == 0);
      @(negedge clock);

      // Random: full range, small coordinates, axis lines and coincident points.
      calm = 0;
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n == 800) hold_off = 1'b1;   // sender keeps offering so the pipe fills
         if (n == 1400) begin
            wait (pending == 0);          // drain completely before resuming
            @(negedge clock);
         end
         kind = $urandom_range(0, 99);
         x1 = any_coord(); y1 = any_coord(); x2 = any_coord(); y2 = any_coord();
         qx = any_coord(); qy = any_coord();
         if (kind < 30) begin
            x1 = $signed(7'($urandom())); y1 = $signed(7'($urandom()));
            x2 = $signed(7'($urandom())); y2 = $signed(7'($urandom()));
            qx = $signed(8'($urandom())); qy = $signed(8'($urandom()));
         end else if (kind < 38) begin
            x2 = x1;
         end else if (kind < 46) begin
            y2 = y1;
         end else if (kind < 52) begin
            x2 = x1;
            y2 = y1;
         end else if (kind < 56) begin
            x2 = x1 + $signed(2'($urandom()));
            y2 = y1 + $signed(2'($urandom()));
         end
         if (calm > 0) begin
            calm--;
            gap = 0;
         end else if ($urandom_range(0, 199) == 0) begin
            calm = $urandom_range(50, 150);
            gap = 0;
         end else begin
            gap = pick_gap();
         end
         offer_line(x1, y1, x2, y2, qx, qy, gap);
      end

      wait (pending == 0);
      repeat (LATENCY + 10) @(posedge clock);
      if (fail_count == 0)
         $display("PASS line_normal_form_signed_distance");
      else
         $display("FAIL line_normal_form_signed_distance");
      $finish;
   end
endmodule
